>>> sv/pcd_pkg.sv
`timescale 1ns / 1ps
package pcd_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int PIDX_W      = 10;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 31;
  localparam int ATOL_W      = 30;
  localparam int DTOL_W      = 31;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_TOL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIST_TOL  = 1'b1;

  localparam logic [ATOL_W-1:0] ANGLE_TOL_RST = 30'd10737;
  localparam logic [DTOL_W-1:0] DIST_TOL_RST  = 31'd655;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NORM = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [2:0] PT_X    = 3'd0;
  localparam logic [2:0] PT_ANYX = 3'd3;

  localparam logic signed [31:0] ONE_Q30     = 32'sh4000_0000;
  localparam logic signed [31:0] NEG_ONE_Q30 = 32'shC000_0000;
  localparam logic signed [31:0] S32_MIN     = 32'sh8000_0000;
  localparam logic signed [31:0] S32_MAX     = 32'sh7FFF_FFFF;
  localparam logic [63:0]        ONE_Q60     = 64'h1000_0000_0000_0000;

  typedef struct packed {
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic signed [31:0] nz;
    logic signed [31:0] d;
  } entry_t;

  typedef struct packed {
    logic             load_in;
    logic             len_mode;
    logic             canon_load;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             flush;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             res_load;
    logic [1:0]       res_status;
    logic             res_new;
    logic [IDX_W-1:0] res_index;
  } dp_cmd_t;

  typedef struct packed {
    logic             len_ok;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic             pipe_empty;
  } dp_stat_t;

  function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
    return (v == S32_MIN) ? S32_MAX : -v;
  endfunction

  function automatic logic [31:0] abs_mag(input logic signed [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

endpackage

>>> sv/pcd_datapath.sv
`timescale 1ns / 1ps
module pcd_datapath (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic signed [31:0]       in_normal_x,
  input  logic signed [31:0]       in_normal_y,
  input  logic signed [31:0]       in_normal_z,
  input  logic signed [31:0]       in_distance,
  input  logic                     cfg_we,
  input  logic [pcd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pcd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  pcd_pkg::dp_cmd_t         cmd,
  output pcd_pkg::dp_stat_t        stat,
  output logic [pcd_pkg::PIDX_W-1:0] out_plane_index,
  output logic                     out_side,
  output logic [2:0]               out_plane_type,
  output logic                     out_is_new,
  output logic [1:0]               out_status
);
  import pcd_pkg::*;

  logic [ATOL_W-1:0] ang_tol_r;
  logic [DTOL_W-1:0] dist_tol_r;
  logic [63:0] lo_r, hi_r, thr_r;
  logic [63:0] tol2, tolt;

  logic signed [31:0] nx_r, ny_r, nz_r, d_r;
  logic signed [31:0] cx_r, cy_r, cz_r, cd_r;
  logic               cside_r;
  logic [2:0]         ctype_r;

  logic signed [31:0] n0 [3];
  logic signed [31:0] n1 [3];
  logic signed [31:0] cn [3];
  logic signed [31:0] d1, cd;
  logic               flip, axis, negd, cside;
  logic [1:0]         ak, dk;
  logic [2:0]         ctype;
  logic [31:0]        mx, my, mz;

  entry_t             mem [TABLE_DEPTH];
  entry_t             rdata_r;
  logic               v1_r, v2_r, v3_r;
  logic [IDX_W-1:0]   idx1_r, idx2_r, idx3_r;
  logic signed [31:0] opa_x, opa_y, opa_z, opb_x, opb_y, opb_z;
  logic signed [63:0] px_r, py_r, pz_r;
  logic [63:0]        sum_r;
  logic signed [32:0] ddiff;
  logic [32:0]        dmag;
  logic               dok2_r, dok3_r;

  logic [PIDX_W-1:0]  pidx_r;
  logic               side_r, new_r;
  logic [2:0]         type_r;
  logic [1:0]         status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ang_tol_r  <= ANGLE_TOL_RST;
      dist_tol_r <= DIST_TOL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ANGLE_TOL: ang_tol_r  <= cfg_data[ATOL_W-1:0];
        CFG_DIST_TOL:  dist_tol_r <= cfg_data[DTOL_W-1:0];
        default: ;
      endcase
    end
  end

  assign tol2 = {3'b0, ang_tol_r, 31'b0};
  assign tolt = {4'b0, ang_tol_r, 30'b0};

  always_ff @(posedge clk) begin
    lo_r  <= (tol2 >= ONE_Q60) ? 64'd0 : ONE_Q60 - tol2;
    hi_r  <= ONE_Q60 + tol2;
    thr_r <= ONE_Q60 - tolt;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      nx_r <= in_normal_x;
      ny_r <= in_normal_y;
      nz_r <= in_normal_z;
      d_r  <= in_distance;
    end
  end

  // canonical form
  always_comb begin
    n0[0] = nx_r;
    n0[1] = ny_r;
    n0[2] = nz_r;
    n1    = n0;
    flip  = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (!flip && n0[k] == NEG_ONE_Q30) begin
        n1[k] = ONE_Q30;
        flip  = 1'b1;
      end
    end
    d1 = flip ? neg_sat(d_r) : d_r;

    axis = 1'b0;
    ak   = 2'd0;
    for (int k = 0; k < 3; k++) begin
      if (!axis && n1[k] == ONE_Q30) begin
        axis = 1'b1;
        ak   = 2'(k);
      end
    end

    mx = abs_mag(n1[0]);
    my = abs_mag(n1[1]);
    mz = abs_mag(n1[2]);
    priority if (mz >= mx && mz >= my) dk = 2'd2;
    else if (my >= mx && my >= mz)     dk = 2'd1;
    else                               dk = 2'd0;
    negd = n1[dk][31];

    if (axis) begin
      cn[0]  = '0;
      cn[1]  = '0;
      cn[2]  = '0;
      cn[ak] = ONE_Q30;
      cd     = d1;
      cside  = flip;
      ctype  = PT_X + {1'b0, ak};
    end else begin
      for (int k = 0; k < 3; k++) begin
        cn[k] = negd ? neg_sat(n1[k]) : n1[k];
      end
      cd    = negd ? neg_sat(d1) : d1;
      cside = flip | negd;
      ctype = PT_ANYX + {1'b0, dk};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.canon_load) begin
      cx_r    <= cn[0];
      cy_r    <= cn[1];
      cz_r    <= cn[2];
      cd_r    <= cd;
      cside_r <= cside;
      ctype_r <= ctype;
    end
  end

  // table
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= {cx_r, cy_r, cz_r, cd_r};
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[cmd.rd_addr];
    end
  end

  // multiply / sum pipe, shared by the length check and the search
  assign opa_x = cmd.len_mode ? nx_r : rdata_r.nx;
  assign opa_y = cmd.len_mode ? ny_r : rdata_r.ny;
  assign opa_z = cmd.len_mode ? nz_r : rdata_r.nz;
  assign opb_x = cmd.len_mode ? nx_r : cx_r;
  assign opb_y = cmd.len_mode ? ny_r : cy_r;
  assign opb_z = cmd.len_mode ? nz_r : cz_r;

  assign ddiff = {rdata_r.d[31], rdata_r.d} - {cd_r[31], cd_r};
  assign dmag  = ddiff[32] ? 33'(-ddiff) : 33'(ddiff);

  always_ff @(posedge clk) begin
    px_r   <= opa_x * opb_x;
    py_r   <= opa_y * opb_y;
    pz_r   <= opa_z * opb_z;
    dok2_r <= dmag < {2'b0, dist_tol_r};
    sum_r  <= 64'(px_r + py_r + pz_r);
    dok3_r <= dok2_r;
    idx1_r <= cmd.rd_addr;
    idx2_r <= idx1_r;
    idx3_r <= idx2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= cmd.rd_en && !cmd.flush;
      v2_r <= v1_r && !cmd.flush;
      v3_r <= v2_r && !cmd.flush;
    end
  end

  assign stat.len_ok     = (sum_r >= lo_r) && (sum_r <= hi_r);
  assign stat.hit        = v3_r && dok3_r && ($signed(sum_r) > $signed(thr_r));
  assign stat.hit_idx    = idx3_r;
  assign stat.pipe_empty = !v1_r && !v2_r && !v3_r;

  // result word
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      pidx_r   <= PIDX_W'(cmd.res_index);
      status_r <= cmd.res_status;
      new_r    <= cmd.res_new;
      side_r   <= (cmd.res_status == ST_NORM) ? 1'b0 : cside_r;
      type_r   <= (cmd.res_status == ST_NORM) ? PT_X : ctype_r;
    end
  end

  assign out_plane_index = pidx_r;
  assign out_side        = side_r;
  assign out_plane_type  = type_r;
  assign out_is_new      = new_r;
  assign out_status      = status_r;

endmodule

>>> sv/pcd_ctrl.sv
`timescale 1ns / 1ps
module pcd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  pcd_pkg::dp_stat_t  stat,
  output pcd_pkg::dp_cmd_t   cmd
);
  import pcd_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LEN0  = 3'd1;
  localparam logic [2:0] S_LEN1  = 3'd2;
  localparam logic [2:0] S_LEN2  = 3'd3;
  localparam logic [2:0] S_CANON = 3'd4;
  localparam logic [2:0] S_SRCH  = 3'd5;
  localparam logic [2:0] S_RES   = 3'd6;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [1:0]       res_status_r, res_status_nxt;
  logic             res_new_r, res_new_nxt;
  logic [IDX_W-1:0] res_index_r, res_index_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    count_nxt      = count_r;
    res_status_nxt = res_status_r;
    res_new_nxt    = res_new_r;
    res_index_nxt  = res_index_r;
    cmd            = '0;
    cmd.rd_addr    = idx_r[IDX_W-1:0];
    cmd.wr_addr    = count_r[IDX_W-1:0];
    cmd.res_status = res_status_r;
    cmd.res_new    = res_new_r;
    cmd.res_index  = res_index_r;
    in_ready       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_LEN0;
        end
      end
      S_LEN0: begin
        cmd.len_mode = 1'b1;
        state_nxt    = S_LEN1;
      end
      S_LEN1: state_nxt = S_LEN2;
      S_LEN2: begin
        if (!stat.len_ok) begin
          res_status_nxt = ST_NORM;
          res_new_nxt    = 1'b0;
          res_index_nxt  = '0;
          state_nxt      = S_RES;
        end else begin
          state_nxt = S_CANON;
        end
      end
      S_CANON: begin
        cmd.canon_load = 1'b1;
        idx_nxt        = '0;
        state_nxt      = S_SRCH;
      end
      S_SRCH: begin
        cmd.rd_en = (idx_r != count_r) && !stat.hit;
        if (cmd.rd_en) begin
          idx_nxt = idx_r + 1'b1;
        end
        if (stat.hit) begin
          cmd.flush      = 1'b1;
          res_status_nxt = ST_OK;
          res_new_nxt    = 1'b0;
          res_index_nxt  = stat.hit_idx;
          state_nxt      = S_RES;
        end else if (idx_r == count_r && stat.pipe_empty) begin
          res_new_nxt = 1'b0;
          state_nxt   = S_RES;
          if (count_r == DEPTH_CNT) begin
            res_status_nxt = ST_FULL;
            res_index_nxt  = '0;
          end else begin
            cmd.wr_en      = 1'b1;
            count_nxt      = count_r + 1'b1;
            res_status_nxt = ST_OK;
            res_new_nxt    = 1'b1;
            res_index_nxt  = count_r[IDX_W-1:0];
          end
        end
      end
      S_RES: begin
        if (!out_valid_r || out_ready) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    priority if (cmd.res_load) out_valid_nxt = 1'b1;
    else if (out_ready)        out_valid_nxt = 1'b0;
    else                       out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_status_r <= res_status_nxt;
    res_new_r    <= res_new_nxt;
    res_index_r  <= res_index_nxt;
  end

  assign out_valid = out_valid_r;

  a_wr_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en |-> count_r < DEPTH_CNT)
    else $error("table write with table full");

  a_hit_srch: assert property (@(posedge clk) disable iff (!rst_n)
    stat.hit |-> state_r == S_SRCH)
    else $error("search hit outside search");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= count_r)
    else $error("search index beyond entry count");

  a_res_word: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |=> out_valid_r)
    else $error("result loaded but no word shown");

endmodule

>>> sv/plane_canonicalize_and_dedup_top.sv
`timescale 1ns / 1ps
// channel   direction  handshake              payload
// in_       input      in_valid / in_ready    normal_x, normal_y, normal_z, distance
// out_      output     out_valid / out_ready  plane_index, side, plane_type, is_new, status
// cfg_      input      cfg_we                 cfg_index, cfg_data
//
// One word at a time: accept, length check (S_LEN0 to S_LEN2), canonical form, then
// the table search reads one entry per cycle through the multiply/sum pipe (read,
// product and sum registers), then the match decision and the result state.
// A match ends the search early.
// Reset is synchronous; the table is empty after it.
// A finished word waits in the output register while the next word is accepted;
// the following result waits until that register is taken.
module plane_canonicalize_and_dedup_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [31:0]          in_normal_x,
  input  logic signed [31:0]          in_normal_y,
  input  logic signed [31:0]          in_normal_z,
  input  logic signed [31:0]          in_distance,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [pcd_pkg::PIDX_W-1:0]  out_plane_index,
  output logic                        out_side,
  output logic [2:0]                  out_plane_type,
  output logic                        out_is_new,
  output logic [1:0]                  out_status,
  input  logic                        cfg_we,
  input  logic [pcd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pcd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pcd_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  pcd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pcd_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_normal_x     (in_normal_x),
    .in_normal_y     (in_normal_y),
    .in_normal_z     (in_normal_z),
    .in_distance     (in_distance),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .cmd             (cmd),
    .stat            (stat),
    .out_plane_index (out_plane_index),
    .out_side        (out_side),
    .out_plane_type  (out_plane_type),
    .out_is_new      (out_is_new),
    .out_status      (out_status)
  );

endmodule
